FILE: hw/rtl/pgqm_pkg.sv
// Shared types and constants for the pixel grid quad mesher.
// No dependencies; imported by every module of the block.
package pgqm_pkg;

    localparam int CoordW       = 11;   // column, row and coordinate width
    localparam int NumW         = 21;   // vertex number width
    localparam int PixW         = 8;    // pixel value width
    localparam int CfgW         = 11;   // widest configuration register
    localparam int RegIdxW      = 1;    // configuration register index width
    localparam int TdataW       = 128;  // packed result fields, byte aligned
    localparam int OutDepth     = 8;    // output queue depth in records
    localparam int DefMaxWidth  = 1024;
    localparam int DefMaxHeight = 1024;

    localparam logic [CfgW-1:0] CfgResetVal = CfgW'(64);

    // Configuration register indexes
    localparam logic [RegIdxW-1:0] REG_IMAGE_WIDTH  = RegIdxW'(0);
    localparam logic [RegIdxW-1:0] REG_IMAGE_HEIGHT = RegIdxW'(1);

    // Record kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUAD   = 1'b1;

    // One entry of the previous-row store
    typedef struct packed {
        logic            filled;
        logic [NumW-1:0] number;
    } row_entry_t;

    // One result record
    typedef struct packed {
        logic              kind;
        logic [CoordW-1:0] vertex_x;
        logic [CoordW-1:0] vertex_y;
        logic [NumW-1:0]   vertex_number;
        logic [NumW-1:0]   corner_top_left;
        logic [NumW-1:0]   corner_bottom_left;
        logic [NumW-1:0]   corner_bottom_right;
        logic [NumW-1:0]   corner_top_right;
        logic              last;
    } record_t;

endpackage

FILE: hw/rtl/pgqm_row_mem.sv
// Previous-row store: fill flag and vertex number per column, registered read.
// Resolves a write to the entry being read and tracks the written prefix.
// Depends on pgqm_pkg.
module pgqm_row_mem #(
    parameter int MAX_WIDTH = pgqm_pkg::DefMaxWidth,
    parameter int IdxW      = $clog2(MAX_WIDTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IdxW-1:0]      rd_idx,
    output pgqm_pkg::row_entry_t rd_entry,
    input  logic                 wr_en,
    input  logic [IdxW-1:0]      wr_idx,
    input  pgqm_pkg::row_entry_t wr_data
);
    import pgqm_pkg::*;

    localparam int Depth = MAX_WIDTH + 1;
    localparam int FillW = $clog2(MAX_WIDTH + 2);

    row_entry_t mem [Depth];
    row_entry_t rd_q_reg;
    row_entry_t fwd_data_reg;
    logic       fwd_hit_reg;
    logic       rd_valid_reg;
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;
    logic [FillW-1:0] rd_idx_ext;
    logic [FillW-1:0] wr_idx_ext;

    assign rd_idx_ext = FillW'(rd_idx);
    assign wr_idx_ext = FillW'(wr_idx);

    // Writes walk columns upward from zero, so the written entries form a prefix.
    always_comb begin
        fill_next = fill_reg;
        if (wr_en && (wr_idx_ext >= fill_reg)) begin
            fill_next = wr_idx_ext + FillW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= mem[rd_idx];
            fwd_data_reg <= wr_data;
            fwd_hit_reg  <= wr_en && (wr_idx == rd_idx);
            rd_valid_reg <= rd_idx_ext < fill_reg;
        end
    end

    // Take the same-cycle write over the stale read; unwritten entries read empty.
    always_comb begin
        if (fwd_hit_reg) begin
            rd_entry = fwd_data_reg;
        end else begin
            rd_entry.filled = rd_q_reg.filled && rd_valid_reg;
            rd_entry.number = rd_q_reg.number;
        end
    end

endmodule

FILE: hw/rtl/pgqm_out_fifo.sv
// Output record queue: takes up to two records a cycle, hands out one.
// Depends on pgqm_pkg.
module pgqm_out_fifo #(
    parameter int DEPTH = pgqm_pkg::OutDepth,
    parameter int CntW  = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_a,
    input  pgqm_pkg::record_t   data_a,
    input  logic                push_b,
    input  pgqm_pkg::record_t   data_b,
    output logic [CntW-1:0]     count,
    output logic                out_valid,
    input  logic                out_ready,
    output pgqm_pkg::record_t   out_data
);
    import pgqm_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    record_t         mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_ptr_b;
    logic            pop;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PtrW'(1);
        end
        return r;
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign wr_ptr_b  = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_a && push_b) begin
            wr_ptr_next = ptr_inc(wr_ptr_b);
        end else if (push_a) begin
            wr_ptr_next = wr_ptr_b;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push_a) + CntW'(push_b) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_a && push_b) begin
            mem_reg[wr_ptr_b] <= data_b;
        end
    end

endmodule

FILE: hw/rtl/pixel_grid_quad_mesher.sv
// Pixel grid quad mesher: turns a raster pixel stream into vertex and quad records.
// Depends on pgqm_pkg, pgqm_row_mem and pgqm_out_fifo.
//
// Usage:
//   s_ carries one word per corner position, (width+1) x (height+1) words per
//   frame in raster order; s_tdata[7:0] is the pixel, ignored on the padding
//   column and row. m_ carries vertex records (m_tuser = 0) and quad records
//   (m_tuser = 1); m_tlast marks the final record caused by an input word.
//   A corner that is no vertex produces no record; when both occur the vertex
//   record comes first.
//   The first record of a word passes the mesh stage registers and the output
//   queue before it appears on m_. Throughput: one word per cycle while the
//   output keeps up; the output moves one record per cycle, so a run of words
//   that cause two records each is held back by s_tready.
//   The previous row lives in a one-port-read, one-port-write memory of
//   MAX_WIDTH+1 entries; a same-entry write in the read cycle is forwarded.
//   Reset clears the position, the vertex counter and the written-column
//   mark, and restores both size registers to 64; no clearing pass is run.
//   When the receiver stalls, records collect in an eight-entry queue and
//   s_tready drops once it cannot take two more records per word in flight.
//   Write image_width (index 0) and image_height (index 1) only while idle.
module pixel_grid_quad_mesher #(
    parameter int MAX_WIDTH  = pgqm_pkg::DefMaxWidth,
    parameter int MAX_HEIGHT = pgqm_pkg::DefMaxHeight
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pgqm_pkg::RegIdxW-1:0]    cfg_index,
    input  logic [pgqm_pkg::CfgW-1:0]       cfg_wdata,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_value
    // record output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [10:0] vertex_x, [21:11] vertex_y, [42:22] vertex_number,
    // [63:43] corner_top_left, [84:64] corner_bottom_left,
    // [105:85] corner_bottom_right, [126:106] corner_top_right, [127] zero
    output logic [pgqm_pkg::TdataW-1:0]     m_tdata,
    output logic                            m_tuser,   // [0] record_kind
    output logic                            m_tlast    // last_of_item
);
    import pgqm_pkg::*;

    localparam int IdxW = $clog2(MAX_WIDTH + 1);
    localparam int CntW = $clog2(OutDepth + 1);

    // configuration
    logic [CfgW-1:0]   width_reg;
    logic [CfgW-1:0]   height_reg;
    logic [CoordW-1:0] eff_w;
    logic [CoordW-1:0] eff_h;

    // scan position (accept stage)
    logic [CoordW-1:0] col_reg, col_next;
    logic [CoordW-1:0] row_reg, row_next;
    logic              accept;
    logic              col_end;
    logic              row_end;
    logic              cur_fill;
    logic [IdxW-1:0]   rd_idx;

    // mesh stage
    logic              b_valid_reg;
    logic [IdxW-1:0]   b_idx_reg;
    logic [CoordW-1:0] b_x_reg;
    logic [CoordW-1:0] b_y_reg;
    logic              b_cur_reg;
    logic              b_col_nz_reg;
    logic              b_row_nz_reg;
    logic              b_frame_end_reg;

    logic [NumW-1:0]   vcnt_reg, vcnt_next;
    logic              left_filled_reg;
    logic [NumW-1:0]   left_num_reg;
    logic              diag_filled_reg;
    logic [NumW-1:0]   diag_num_reg;

    row_entry_t        up_entry;
    row_entry_t        wr_entry;
    logic              up;
    logic              left;
    logic              diag;
    logic              is_vertex;
    logic [NumW-1:0]   vnum;

    record_t           vert_rec;
    record_t           quad_rec;
    record_t           out_rec;
    logic [CntW-1:0]   fifo_count;
    logic              fifo_valid;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CfgResetVal;
            height_reg <= CfgResetVal;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturate the sizes at MAX_WIDTH and MAX_HEIGHT
    always_comb begin
        eff_w = (int'(width_reg) > MAX_WIDTH) ? CoordW'(MAX_WIDTH) : width_reg;
        eff_h = (int'(height_reg) > MAX_HEIGHT) ? CoordW'(MAX_HEIGHT) : height_reg;
    end

    // ---------------------------------------------------------------
    // Accept stage: hold the scan position, issue the previous-row read
    // ---------------------------------------------------------------
    // Leave room for both records of the word in flight and of this one.
    assign s_tready = ({1'b0, fifo_count} + (b_valid_reg ? (CntW + 1)'(2) : '0))
                      <= (CntW + 1)'(OutDepth - 2);
    assign accept   = s_tvalid && s_tready;

    assign col_end  = col_reg >= eff_w;
    assign row_end  = row_reg >= eff_h;
    assign cur_fill = !col_end && !row_end && (s_tdata[PixW-1:0] != '0);
    assign rd_idx   = (int'(col_reg) > MAX_WIDTH) ? IdxW'(MAX_WIDTH) : IdxW'(col_reg);

    // Advance along the row; wrap at the padding column, then at the padding row.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + CoordW'(1);
            end else begin
                col_next = col_reg + CoordW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_idx_reg       <= rd_idx;
            b_x_reg         <= col_reg;
            b_y_reg         <= eff_h - row_reg;
            b_cur_reg       <= cur_fill;
            b_col_nz_reg    <= col_reg != '0;
            b_row_nz_reg    <= row_reg != '0;
            b_frame_end_reg <= col_end && row_end;
        end
    end

    pgqm_row_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .IdxW      (IdxW)
    ) u_row_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_idx   (rd_idx),
        .rd_entry (up_entry),
        .wr_en    (b_valid_reg),
        .wr_idx   (b_idx_reg),
        .wr_data  (wr_entry)
    );

    // ---------------------------------------------------------------
    // Mesh stage: decide vertex and quad, write the row entry back
    // ---------------------------------------------------------------
    assign up        = b_row_nz_reg && up_entry.filled;
    assign left      = b_col_nz_reg && left_filled_reg;
    assign diag      = b_row_nz_reg && b_col_nz_reg && diag_filled_reg;
    assign is_vertex = b_cur_reg || up || left || diag;
    assign vnum      = is_vertex ? vcnt_reg : '0;

    // Keep the old number where this corner is no vertex
    assign wr_entry.filled = b_cur_reg;
    assign wr_entry.number = is_vertex ? vcnt_reg : up_entry.number;

    always_comb begin
        vcnt_next = vcnt_reg;
        if (b_valid_reg) begin
            if (b_frame_end_reg) begin
                vcnt_next = '0;
            end else if (is_vertex) begin
                vcnt_next = vcnt_reg + NumW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg        <= '0;
            left_filled_reg <= 1'b0;
            left_num_reg    <= '0;
            diag_filled_reg <= 1'b0;
            diag_num_reg    <= '0;
        end else begin
            vcnt_reg <= vcnt_next;
            if (b_valid_reg) begin
                left_filled_reg <= b_cur_reg;
                left_num_reg    <= vnum;
                diag_filled_reg <= up;
                diag_num_reg    <= up_entry.number;
            end
        end
    end

    always_comb begin
        vert_rec                     = '0;
        vert_rec.kind                = KIND_VERTEX;
        vert_rec.vertex_x            = b_x_reg;
        vert_rec.vertex_y            = b_y_reg;
        vert_rec.vertex_number       = vnum;
        vert_rec.last                = !diag;

        quad_rec                     = '0;
        quad_rec.kind                = KIND_QUAD;
        quad_rec.corner_top_left     = diag_num_reg;
        quad_rec.corner_bottom_left  = left_num_reg;
        quad_rec.corner_bottom_right = vnum;
        quad_rec.corner_top_right    = up_entry.number;
        quad_rec.last                = 1'b1;
    end

    // A quad always comes with a vertex, so it rides in the second slot.
    pgqm_out_fifo #(
        .DEPTH (OutDepth),
        .CntW  (CntW)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (b_valid_reg && is_vertex),
        .data_a    (vert_rec),
        .push_b    (b_valid_reg && diag),
        .data_b    (quad_rec),
        .count     (fifo_count),
        .out_valid (fifo_valid),
        .out_ready (m_tready),
        .out_data  (out_rec)
    );

    assign m_tvalid = fifo_valid;
    assign m_tuser  = out_rec.kind;
    assign m_tlast  = out_rec.last;
    assign m_tdata  = {1'b0,
                       out_rec.corner_top_right,
                       out_rec.corner_bottom_right,
                       out_rec.corner_bottom_left,
                       out_rec.corner_top_left,
                       out_rec.vertex_number,
                       out_rec.vertex_y,
                       out_rec.vertex_x};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fifo_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fifo_count) <= OutDepth)
        else $error("output queue overflow");

    a_quad_needs_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && diag) |-> is_vertex)
        else $error("quad record without its vertex");

    a_counter_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_frame_end_reg) |=> (vcnt_reg == '0))
        else $error("vertex counter did not restart at frame end");

    a_column_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(col_reg) <= MAX_WIDTH)
        else $error("column position beyond row store");

endmodule

FILE: tb/pgqm_mesh_checker.sv
// Record checker for the pixel grid quad mesher: predicts the vertex and quad
// records of every accepted pixel word and compares them with the m_ stream.
// Depends on pgqm_pkg; instantiated beside the block by the testbench top.
module pgqm_mesh_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pgqm_pkg::RegIdxW-1:0]  cfg_index,
    input  logic [pgqm_pkg::CfgW-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [7:0] pixel_value
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [10:0] vertex_x, [21:11] vertex_y, [42:22] vertex_number,
    // [63:43] corner_top_left, [84:64] corner_bottom_left,
    // [105:85] corner_bottom_right, [126:106] corner_top_right, [127] zero
    input  logic [pgqm_pkg::TdataW-1:0]   m_tdata,
    input  logic                          m_tuser,    // [0] record_kind
    input  logic                          m_tlast,    // last_of_item
    output int unsigned                   records_pending,
    output int unsigned                   error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pgqm_pkg::*;

    localparam int RowDepth = DefMaxWidth + 1;
    localparam int PadLsb   = 2 * CoordW + 5 * NumW;
    localparam int MaxShown = 100;

    logic [CfgW-1:0]   width_reg;
    logic [CfgW-1:0]   height_reg;
    logic [CoordW-1:0] col_at;
    logic [CoordW-1:0] row_at;
    logic [NumW-1:0]   next_number;
    logic              row_fill   [RowDepth];
    logic [NumW-1:0]   row_number [RowDepth];
    logic              left_fill;
    logic [NumW-1:0]   left_number;
    logic              diag_fill;
    logic [NumW-1:0]   diag_number;
    record_t           records_due [$];
    int unsigned       records_seen;

    task automatic report_mismatch(input string msg);
        if (error_count < MaxShown) $display("%0t ns mesh check: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("record %0d %s: got %0d, want %0d",
                                      records_seen, name, got, want));
    endtask

    function automatic logic [CoordW-1:0] clamp_side(input logic [CfgW-1:0] value,
                                                     input int unsigned limit);
        return (value > limit) ? CoordW'(limit) : CoordW'(value);
    endfunction

    // Predict the records of one corner word and advance the raster position.
    task automatic mesh_corner(input logic [PixW-1:0] pixel);
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
        int unsigned       idx;
        logic              cur;
        logic              up;
        logic              left;
        logic              diag;
        logic              is_vertex;
        logic [NumW-1:0]   up_num;
        logic [NumW-1:0]   vnum;
        record_t           rec;
        w         = clamp_side(width_reg, DefMaxWidth);
        h         = clamp_side(height_reg, DefMaxHeight);
        idx       = (col_at > DefMaxWidth) ? DefMaxWidth : col_at;
        cur       = !((col_at >= w) || (row_at >= h)) && (pixel != '0);
        up        = (row_at != 0) && row_fill[idx];
        up_num    = row_number[idx];
        left      = (col_at != 0) && left_fill;
        diag      = (row_at != 0) && (col_at != 0) && diag_fill;
        is_vertex = cur || up || left || diag;
        vnum      = '0;
        if (is_vertex) begin
            vnum               = next_number;
            next_number        = next_number + 1'b1;
            rec                = '0;
            rec.kind           = KIND_VERTEX;
            rec.vertex_x       = col_at;
            rec.vertex_y       = h - row_at;
            rec.vertex_number  = vnum;
            rec.last           = !diag;
            records_due.push_back(rec);
        end
        if (diag) begin
            rec                     = '0;
            rec.kind                = KIND_QUAD;
            rec.corner_top_left     = diag_number;
            rec.corner_bottom_left  = left_number;
            rec.corner_bottom_right = vnum;
            rec.corner_top_right    = up_num;
            rec.last                = 1'b1;
            records_due.push_back(rec);
        end
        // the old upper entry of this column is the diagonal of the next corner
        diag_fill     = up;
        diag_number   = up_num;
        row_fill[idx] = cur;
        if (is_vertex) row_number[idx] = vnum;
        left_fill     = cur;
        left_number   = vnum;
        if (col_at >= w) begin
            col_at = '0;
            if (row_at >= h) begin
                row_at      = '0;
                next_number = '0;
            end else begin
                row_at = row_at + 1'b1;
            end
        end else begin
            col_at = col_at + 1'b1;
        end
    endtask

    always @(posedge aclk) begin : watch
        record_t want;
        if (!aresetn) begin
            width_reg   = CfgResetVal;
            height_reg  = CfgResetVal;
            col_at      = '0;
            row_at      = '0;
            next_number = '0;
            left_fill   = 1'b0;
            left_number = '0;
            diag_fill   = 1'b0;
            diag_number = '0;
            foreach (row_fill[k]) begin
                row_fill[k]   = 1'b0;
                row_number[k] = '0;
            end
            records_due.delete();
            records_seen = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_wdata;
                else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_wdata;
            end
            // check outputs before predicting, so a stray record never meets
            // an expectation pushed in the same cycle
            if (m_tvalid && m_tready) begin
                if (records_due.size() == 0) begin
                    report_mismatch($sformatf("record %0d arrived with none expected",
                                              records_seen));
                end else begin
                    want = records_due.pop_front();
                    check_field("record_kind", m_tuser, want.kind);
                    check_field("vertex_x", m_tdata[0 +: CoordW], want.vertex_x);
                    check_field("vertex_y", m_tdata[CoordW +: CoordW], want.vertex_y);
                    check_field("vertex_number", m_tdata[2*CoordW +: NumW],
                                want.vertex_number);
                    check_field("corner_top_left", m_tdata[2*CoordW + NumW +: NumW],
                                want.corner_top_left);
                    check_field("corner_bottom_left", m_tdata[2*CoordW + 2*NumW +: NumW],
                                want.corner_bottom_left);
                    check_field("corner_bottom_right", m_tdata[2*CoordW + 3*NumW +: NumW],
                                want.corner_bottom_right);
                    check_field("corner_top_right", m_tdata[2*CoordW + 4*NumW +: NumW],
                                want.corner_top_right);
                    check_field("last_of_item", m_tlast, want.last);
                    check_field("tdata fill bits", m_tdata[TdataW-1:PadLsb], 0);
                end
                records_seen++;
            end
            if (s_tvalid && s_tready) mesh_corner(s_tdata);
        end
        records_pending <= records_due.size();
    end

endmodule

FILE: tb/pixel_grid_quad_mesher_test.sv
// Testbench top for the pixel grid quad mesher: streams pixel frames of many
// sizes with random gaps and stalls, and reports the verdict of pgqm_mesh_checker.
// Depends on pgqm_pkg, pgqm_mesh_checker and the block's RTL.
module pixel_grid_quad_mesher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgqm_pkg::*;

    localparam longint unsigned CycleLimit = 5_000_000;
    localparam int SettleCycles = 8;     // let the pipeline drain; keep margin
    localparam int RandomItems  = 150;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [RegIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0]    cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // [7:0] pixel_value
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    // [10:0] vertex_x, [21:11] vertex_y, [42:22] vertex_number,
    // [63:43] corner_top_left, [84:64] corner_bottom_left,
    // [105:85] corner_bottom_right, [126:106] corner_top_right, [127] zero
    logic [TdataW-1:0]  m_tdata;
    logic               m_tuser;          // [0] record_kind
    logic               m_tlast;          // last_of_item

    int unsigned        records_pending;
    int unsigned        error_count;

    // Stimulus bookkeeping: the raster position the block should be at, so
    // frames can be finished after a size change.
    int unsigned        side_w     = DefMaxWidth < 64 ? DefMaxWidth : 64;
    int unsigned        side_h     = DefMaxHeight < 64 ? DefMaxHeight : 64;
    int unsigned        pos_col    = 0;
    int unsigned        pos_row    = 0;
    int unsigned        items_sent = 0;
    int unsigned        fill_pct   = 50;
    bit                 idling     = 1'b1;
    int unsigned        ready_hold = 0;
    longint unsigned    cycle_count = 0;

    pixel_grid_quad_mesher u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    pgqm_mesh_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .records_pending (records_pending),
        .error_count     (error_count)
    );

    always #5 aclk = ~aclk;

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("** pixel_grid_quad_mesher: FAILED **");
            $finish;
        end
    end

    // Receiver: hold ready for random stretches, mostly short stalls and a few
    // long ones; keep ready high while idling is off.
    always @(posedge aclk) begin : ready_drive
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idling) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (roll < 60) begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 7);
        end else if (roll < 95) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(10, 40);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idling) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PixW-1:0] pick_pixel();
        if ($urandom_range(0, 99) < fill_pct) return PixW'($urandom_range(1, 255));
        return '0;
    endfunction

    // Mostly small sides, now and then a wider one, rarely zero.
    function automatic int unsigned pick_side();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return 0;
        if (roll < 85) return $urandom_range(1, 8);
        return $urandom_range(9, 20);
    endfunction

    // Send one corner word after a random gap and advance the raster position.
    task automatic send_word(input logic [PixW-1:0] pixel);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (pos_col >= side_w) begin
            pos_col = 0;
            pos_row = (pos_row >= side_h) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    // Drop valid and wait until every predicted record has come out, then let
    // the pipeline settle in case the last words made no record.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (records_pending != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [RegIdxW-1:0] index, input int unsigned value);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= CfgW'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == REG_IMAGE_WIDTH) side_w = (value > DefMaxWidth) ? DefMaxWidth : value;
        else side_h = (value > DefMaxHeight) ? DefMaxHeight : value;
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Send words until the position wraps back to the first corner.
    task automatic finish_frame();
        do send_word(pick_pixel()); while (pos_col != 0 || pos_row != 0);
    endtask

    initial begin : stimulus
        int unsigned random_goal;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset sizes: the first words see height 64; then end the frame early
        // by making row 0 the last row and shrinking the width mid-frame.
        send_word(8'hFF);
        send_word(8'h00);
        send_word(8'h01);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_IMAGE_WIDTH, 3);
        finish_frame();

        // Single filled pixel: four vertices and one quad.
        set_size(1, 1);
        repeat (4) send_word(8'hFF);

        // One row of two pixels, nonzero values on the padding positions.
        set_size(2, 1);
        send_word(8'h80);
        send_word(8'h00);
        send_word(8'hAA);
        send_word(8'h7F);
        send_word(8'h01);
        send_word(8'h55);

        // Size changes in the middle of a frame.
        fill_pct = 60;
        set_size(3, 2);
        repeat (5) send_word(pick_pixel());
        write_reg(REG_IMAGE_HEIGHT, 6);     // grow the frame downward
        finish_frame();

        set_size(5, 5);
        repeat (14) send_word(pick_pixel());
        write_reg(REG_IMAGE_HEIGHT, 1);     // current row lies past the end: y wraps
        finish_frame();

        set_size(6, 4);
        repeat (12) send_word(pick_pixel());
        write_reg(REG_IMAGE_WIDTH, 2);      // column already beyond the new width
        finish_frame();

        set_size(6, 4);
        repeat (9) send_word(pick_pixel());
        write_reg(REG_IMAGE_WIDTH, 3);
        finish_frame();

        set_size(2, 3);
        repeat (2) send_word(pick_pixel());
        write_reg(REG_IMAGE_WIDTH, 5);      // widen while still on the first row
        finish_frame();

        // Zero sides: padding only, no records.
        fill_pct = 100;
        set_size(0, 3);
        finish_frame();
        set_size(3, 0);
        finish_frame();
        set_size(0, 0);
        finish_frame();

        // Random frames; some get a size change partway through. Height may
        // change freely, width only shrinks so the row above stays written.
        random_goal = items_sent + RandomItems;
        while (items_sent < random_goal) begin
            idling = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 4))
                0: fill_pct = 0;
                1: fill_pct = 15;
                2: fill_pct = 50;
                3: fill_pct = 85;
                default: fill_pct = 100;
            endcase
            set_size(pick_side(), pick_side());
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(0, (side_w + 1) * (side_h + 1) - 1))
                    send_word(pick_pixel());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 12));
                else if (side_w != 0)
                    write_reg(REG_IMAGE_WIDTH, $urandom_range(0, side_w - 1));
            end
            finish_frame();
        end

        // Largest sides, through oversized register values that saturate: run
        // the first row out to the last column, then close the frame at once.
        idling   = 1'b0;
        fill_pct = 50;
        set_size(2047, 2047);
        repeat (DefMaxWidth + 1) send_word(pick_pixel());
        write_reg(REG_IMAGE_HEIGHT, 1);     // second row becomes the last row
        write_reg(REG_IMAGE_WIDTH, 0);      // its first column ends the frame
        finish_frame();

        quiesce();
        if (error_count == 0) begin
            $display("** pixel_grid_quad_mesher: PASSED **");
        end else begin
            $display("** pixel_grid_quad_mesher: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/pgqm_pkg.sv
hw/rtl/pgqm_row_mem.sv
hw/rtl/pgqm_out_fifo.sv
hw/rtl/pixel_grid_quad_mesher.sv
tb/pgqm_mesh_checker.sv
tb/pixel_grid_quad_mesher_test.sv
